[hw/rtl/csu_pkg.sv]
// Shared types, hash constants and mixing functions for the count sketch block.
`timescale 1ns / 1ps
package csu_pkg;

  typedef struct packed {
    logic               cmd;
    logic        [31:0] flow_id;
    logic signed [31:0] volume;
    logic signed [31:0] card_inc;
    logic        [3:0]  first_row;
    logic        [3:0]  end_row;
  } in_t;

  typedef struct packed {
    logic        [2:0]  row_index;
    logic signed [31:0] volume_estimate;
    logic signed [31:0] card_count;
    logic signed [63:0] total_volume;
    logic signed [63:0] total_card;
    logic               last;
  } out_t;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic k1;
    logic k2;
    logic pre_sign;
    logic pre_col;
    logic mul3;
    logic mul4;
    logic mod_clr;
    logic mod_step;
    logic fix;
    logic wr;
    logic out_load;
    logic row_next;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic row_end;
    logic mod_last;
    logic is_query;
    logic out_free;
  } ctl_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Seed mix, length xor and first fold of the finaliser
  function automatic logic [31:0] mm_pre(input logic [31:0] k, input logic [31:0] seed);
    logic [31:0] t;
    t = rotl(seed ^ k, 13);
    t = (t << 2) + t + MM_N;
    t = t ^ 32'd4;
    return t ^ (t >> 16);
  endfunction

endpackage

[hw/rtl/csu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module csu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/csu_ctrl.sv]
// Sequencing state machine for the count sketch block.
`timescale 1ns / 1ps
module csu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  csu_pkg::ctl_sts_t sts,
  output csu_pkg::ctl_cmd_t cmd
);
  import csu_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_K1   = 4'd2;
  localparam logic [3:0] S_K2   = 4'd3;
  localparam logic [3:0] S_ROW  = 4'd4;
  localparam logic [3:0] S_SA   = 4'd5;
  localparam logic [3:0] S_S1   = 4'd6;
  localparam logic [3:0] S_S2   = 4'd7;
  localparam logic [3:0] S_CA   = 4'd8;
  localparam logic [3:0] S_C1   = 4'd9;
  localparam logic [3:0] S_C2   = 4'd10;
  localparam logic [3:0] S_MOD  = 4'd11;
  localparam logic [3:0] S_FIX  = 4'd12;
  localparam logic [3:0] S_RD   = 4'd13;
  localparam logic [3:0] S_ACT  = 4'd14;

  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_K1;
        end
      end
      S_K1: begin
        cmd.k1     = 1'b1;
        state_next = S_K2;
      end
      S_K2: begin
        cmd.k2     = 1'b1;
        state_next = S_ROW;
      end
      S_ROW: begin
        state_next = sts.row_end ? S_IDLE : S_SA;
      end
      S_SA: begin
        cmd.pre_sign = 1'b1;
        state_next   = S_S1;
      end
      S_S1: begin
        cmd.mul3   = 1'b1;
        state_next = S_S2;
      end
      S_S2: begin
        cmd.mul4   = 1'b1;
        state_next = S_CA;
      end
      S_CA: begin
        cmd.pre_col = 1'b1;
        state_next  = S_C1;
      end
      S_C1: begin
        cmd.mul3   = 1'b1;
        state_next = S_C2;
      end
      S_C2: begin
        cmd.mul4    = 1'b1;
        cmd.mod_clr = 1'b1;
        state_next  = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        state_next = S_ACT;
      end
      S_ACT: begin
        if (!sts.is_query) begin
          cmd.wr       = 1'b1;
          cmd.row_next = 1'b1;
          state_next   = S_ROW;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.row_next = 1'b1;
          state_next   = S_ROW;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  a_stall_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> in_stall) else $error("request taken during clearing pass");
  a_fix_after_mod: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |-> $past(cmd.mod_step)) else $error("column fixed before remainder done");
  a_act_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |=> (state == S_ACT)) else $error("read not followed by action");
endmodule

[hw/rtl/csu_dp.sv]
// Datapath: hashing, column reduction, cell store, totals and result register.
`timescale 1ns / 1ps
module csu_dp #(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  csu_pkg::ctl_cmd_t cmd,
  output csu_pkg::ctl_sts_t sts,
  input  csu_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output csu_pkg::out_t     out_data
);
  import csu_pkg::*;

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = CW + 1;
  localparam logic [RW-1:0] CMOD = RW'(COLUMNS);
  localparam logic [RW-1:0] KMOD = RW'((64'd1 << 32) % COLUMNS);

  in_t                item;
  logic [31:0]        kreg;
  logic [31:0]        h;
  logic               sgn;
  logic [RW-1:0]      rem;
  logic [2:0]         mcnt;
  logic [CW-1:0]      col;
  logic [4:0]         row;
  logic [4:0]         top;
  logic [AW-1:0]      clr_addr;
  logic signed [63:0] vsum;
  logic signed [63:0] csum;

  logic [31:0]   mul_a, mul_b, prod, hfin, hsh;
  logic [3:0]    nib;
  logic [RW-1:0] rem_next;
  logic [RW-1:0] col_fix;
  logic [AW-1:0] addr, waddr;
  logic          we;
  logic [63:0]   wdata, rdata;
  logic [31:0]   cell_v, cell_c, vol_add;
  logic [4:0]    end_cut;

  assign hfin   = h ^ (h >> 16);
  assign cell_v = rdata[63:32];
  assign cell_c = rdata[31:0];
  assign end_cut = ({1'b0, in_data.end_row} < 5'(ROWS)) ? {1'b0, in_data.end_row} : 5'(ROWS);

  // One shared 32-bit multiplier
  always_comb begin
    mul_a = h;
    mul_b = MM_F1;
    if (cmd.k1) begin
      mul_a = kreg;
      mul_b = MM_C1;
    end else if (cmd.k2) begin
      mul_a = rotl(kreg, 15);
      mul_b = MM_C2;
    end else if (cmd.mul4) begin
      mul_a = h ^ (h >> 13);
      mul_b = MM_F2;
    end
    prod = mul_a * mul_b;
  end

  // Four remainder bits per cycle
  always_comb begin
    hsh      = hfin << {mcnt, 2'b00};
    nib      = hsh[31:28];
    rem_next = rem;
    for (int i = 0; i < 4; i++) begin
      rem_next = {rem_next[RW-2:0], nib[3-i]};
      if (rem_next >= CMOD) rem_next = rem_next - CMOD;
    end
  end

  // Negative hash: take off 2^32 mod COLUMNS and wrap into range
  always_comb begin
    col_fix = rem;
    if (hfin[31]) begin
      col_fix = (rem >= KMOD) ? rem - KMOD : rem + CMOD - KMOD;
    end
  end

  assign addr    = AW'(32'(row) * COLUMNS + 32'(col));
  assign vol_add = sgn ? item.volume : 32'd0 - item.volume;
  assign we      = cmd.clr_step | cmd.wr;
  assign waddr   = cmd.clr_step ? clr_addr : addr;
  assign wdata   = cmd.clr_step ? 64'd0 : {cell_v + vol_add, cell_c + item.card_inc};

  csu_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
      kreg <= in_data.flow_id;
      row  <= {1'b0, in_data.first_row};
      top  <= end_cut;
    end
    if (cmd.row_next) row <= row + 5'd1;
    if (cmd.k1 || cmd.k2) kreg <= prod;
    if (cmd.mul3 || cmd.mul4) h <= prod;
    if (cmd.pre_sign) h <= mm_pre(kreg, 32'(row) + 32'(ROWS));
    if (cmd.pre_col) begin
      sgn <= hfin[0];
      h   <= mm_pre(kreg, 32'(row));
    end
    if (cmd.mod_clr) begin
      rem  <= '0;
      mcnt <= '0;
    end
    if (cmd.mod_step) begin
      rem  <= rem_next;
      mcnt <= mcnt + 3'd1;
    end
    if (cmd.fix) col <= CW'(col_fix);
    if (cmd.out_load) begin
      out_data.row_index       <= row[2:0];
      out_data.volume_estimate <= sgn ? cell_v : 32'd0 - cell_v;
      out_data.card_count      <= cell_c;
      out_data.total_volume    <= vsum;
      out_data.total_card      <= csum;
      out_data.last            <= (row + 5'd1 == top);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      vsum      <= '0;
      csum      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + AW'(1);
      if (cmd.accept && in_data.cmd == CMD_UPDATE && in_data.first_row == 4'd0
          && in_data.end_row != 4'd0) begin
        vsum <= vsum + {{32{in_data.volume[31]}}, in_data.volume};
        csum <= csum + {{32{in_data.card_inc[31]}}, in_data.card_inc};
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.clr_last = (clr_addr == AW'(DEPTH - 1));
  assign sts.row_end  = (row >= top);
  assign sts.mod_last = (mcnt == 3'd7);
  assign sts.is_query = (item.cmd == CMD_QUERY);
  assign sts.out_free = !out_valid || !out_stall;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free) else $error("result register overwritten");
  a_wr_update: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (item.cmd == CMD_UPDATE)) else $error("cell write on a query");
  a_row_load: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (row == {1'b0, $past(in_data.first_row)}))
    else $error("row counter not loaded from request");
endmodule

[hw/rtl/count_sketch_update_query.sv]
// Top level of the count sketch: controller plus datapath.
// Sequence: request taken, key mixing, then the per-row sequence below for each row in range.
// Per row: sign hash, column hash, remainder (4 bits a cycle), fix, read and action, row check.
// Throughput: one request at a time; a query row holds while the previous result
// waits for the receiver.
// Reset: synchronous; a clearing pass zeroes every cell of the RAM first.
`timescale 1ns / 1ps
module count_sketch_update_query #(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  csu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output csu_pkg::out_t out_data
);
  import csu_pkg::*;

  // Command and status bundles between the controller and the datapath
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Controller: walks each request through key mixing and the per-row sequence,
  // and holds the input stalled while a request is in flight or the RAM is clearing.
  csu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: shared multiplier for the hash, remainder unit, cell RAM with
  // read-modify-write for updates, running totals and the result register.
  // The result register lets the next request start while a result waits.
  csu_dp #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule
